### design/sbem_pkg.sv
// Package for the big-endian byte memory: constants, codes, types and helpers.
`default_nettype none
package sbem_pkg;

  localparam int STORE_BYTES_DEF = 65536;
  localparam int DATA_W = 64;
  localparam int ADDR_W = 64;

  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  localparam logic [1:0] SIZE_BYTE   = 2'd0;
  localparam logic [1:0] SIZE_HALF   = 2'd1;
  localparam logic [1:0] SIZE_WORD   = 2'd2;
  localparam logic [1:0] SIZE_DOUBLE = 2'd3;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CHECK,
    ST_ACCESS,
    ST_DRAIN,
    ST_FINISH
  } seq_state_t;

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic              fault;
  } rsp_t;

  // Number of bytes moved by an access of the given size.
  function automatic logic [3:0] byte_count(input logic [1:0] size);
    logic [3:0] n;
    unique case (size)
      SIZE_BYTE:   n = 4'd1;
      SIZE_HALF:   n = 4'd2;
      SIZE_WORD:   n = 4'd4;
      SIZE_DOUBLE: n = 4'd8;
      default:     n = 4'd1;
    endcase
    return n;
  endfunction

  // Index of the last byte of an access.
  function automatic logic [2:0] last_index(input logic [1:0] size);
    logic [2:0] n;
    unique case (size)
      SIZE_BYTE:   n = 3'd0;
      SIZE_HALF:   n = 3'd1;
      SIZE_WORD:   n = 3'd3;
      SIZE_DOUBLE: n = 3'd7;
      default:     n = 3'd0;
    endcase
    return n;
  endfunction

  // Unused high bytes of the write data above the access width.
  function automatic logic [2:0] pad_bytes(input logic [1:0] size);
    logic [2:0] n;
    unique case (size)
      SIZE_BYTE:   n = 3'd7;
      SIZE_HALF:   n = 3'd6;
      SIZE_WORD:   n = 3'd4;
      SIZE_DOUBLE: n = 3'd0;
      default:     n = 3'd0;
    endcase
    return n;
  endfunction

endpackage
`default_nettype wire

### design/sbem_if.sv
// Channel interfaces: access requests, results and the base address write.
`default_nettype none
interface sbem_req_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [1:0]  size_code;
  logic [63:0] address;
  logic [63:0] write_data;
  modport source (output valid, output operation, output size_code, output address,
                  output write_data, input ready);
  modport sink (input valid, input operation, input size_code, input address,
                input write_data, output ready);
endinterface

interface sbem_rsp_if;
  logic        valid;
  logic        ready;
  logic [63:0] read_data;
  logic        fault;
  modport source (output valid, output read_data, output fault, input ready);
  modport sink (input valid, input read_data, input fault, output ready);
endinterface

interface sbem_cfg_if;
  logic        valid;
  logic        ready;
  logic [63:0] base_address;
  modport source (output valid, output base_address, input ready);
  modport sink (input valid, input base_address, output ready);
endinterface
`default_nettype wire

### design/sbem_ram.sv
// Generic single-port synchronous RAM with a registered read.
`default_nettype none
module sbem_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 65536
) (
  input  wire logic                     clk,
  input  wire logic                     en,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule
`default_nettype wire

### design/sbem_seq.sv
// Access sequencer: range check, byte-by-byte store access and the reset clearing pass.
`default_nettype none
module sbem_seq #(
  parameter int STORE_BYTES = 65536
) (
  input  wire logic         clk,
  input  wire logic         rst,
  sbem_req_if.sink          req,
  input  wire logic [63:0]  base_address,
  output logic              done_valid,
  input  wire logic         done_ready,
  output sbem_pkg::rsp_t    done_rsp
);
  import sbem_pkg::*;

  localparam int AW = $clog2(STORE_BYTES);

  seq_state_t state, state_next;

  logic              op;
  logic [1:0]        size;
  logic [ADDR_W-1:0] off;
  logic              below;
  logic [DATA_W-1:0] wdata;
  logic [DATA_W-1:0] acc;
  logic [2:0]        idx;
  logic              fault_r;
  logic              fault_r_next;
  logic              rd_pend;
  logic [AW-1:0]     clr_addr;

  logic              ram_en;
  logic              ram_we;
  logic [AW-1:0]     ram_addr;
  logic [7:0]        ram_wdata;
  logic [7:0]        ram_rdata;

  sbem_ram #(
    .WIDTH(8),
    .DEPTH(STORE_BYTES)
  ) u_store (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // The whole access fits when the offset leaves room for every byte of it.
  assign fault_r_next = below || (off > (64'(STORE_BYTES) - 64'(byte_count(size))));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    req.ready  = 1'b0;
    done_valid = 1'b0;
    ram_en     = 1'b0;
    ram_we     = 1'b0;
    ram_addr   = clr_addr;
    ram_wdata  = 8'h00;
    unique case (state)
      ST_CLEAR: begin
        ram_en = 1'b1;
        ram_we = 1'b1;
        if (clr_addr == AW'(STORE_BYTES - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        req.ready = 1'b1;
        if (req.valid) begin
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        state_next = fault_r_next ? ST_FINISH : ST_ACCESS;
      end
      ST_ACCESS: begin
        ram_en    = 1'b1;
        ram_we    = (op == OP_WRITE);
        ram_addr  = off[AW-1:0] + AW'(idx);
        ram_wdata = wdata[DATA_W-1 -: 8];
        if (idx == last_index(size)) begin
          state_next = (op == OP_WRITE) ? ST_FINISH : ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        done_valid = 1'b1;
        if (done_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
      rd_pend  <= 1'b0;
    end else begin
      rd_pend <= (state == ST_ACCESS) && (op == OP_READ);
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && req.valid) begin
      op            <= req.operation;
      size          <= req.size_code;
      wdata         <= req.write_data;
      {below, off}  <= {1'b0, req.address} - {1'b0, base_address};
    end
    if (state == ST_CHECK) begin
      fault_r <= fault_r_next;
      // Move the low bytes of the write data to the top so each beat takes the top byte.
      wdata   <= wdata << {pad_bytes(size), 3'b000};
      idx     <= 3'd0;
      acc     <= '0;
    end
    if (state == ST_ACCESS) begin
      idx   <= idx + 3'd1;
      wdata <= {wdata[DATA_W-9:0], 8'h00};
    end
    if (rd_pend) begin
      acc <= {acc[DATA_W-9:0], ram_rdata};
    end
  end

  assign done_rsp.read_data = acc;
  assign done_rsp.fault     = fault_r;

  a_no_access_on_fault: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ACCESS) |-> !fault_r)
    else $error("store accessed for a faulting request");

  a_drain_has_read: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DRAIN) |-> (rd_pend && op == OP_READ))
    else $error("drain cycle without a read in flight");

  a_index_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ACCESS) |-> (idx <= last_index(size)))
    else $error("byte index ran past the access width");

  a_write_reads_zero: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FINISH && (op == OP_WRITE || fault_r)) |-> (acc == '0))
    else $error("nonzero read data on a write or fault");

endmodule
`default_nettype wire

### design/sized_big_endian_memory_top.sv
// Flow: a request is taken in IDLE and range-checked in CHECK, then ACCESS moves its bytes
// and reads pass DRAIN; a fault goes from CHECK straight to FINISH. The result is registered.
// Requests: the sequencer takes a new request only after the last one's result has left
// FINISH; the store has a single byte-wide port, so bytes are accessed one at a time.
// Reset: base_address returns to 0 and a clearing pass over all STORE_BYTES bytes zeroes the
// store, during which no request is taken; base address writes are taken at any time.
`default_nettype none
module sized_big_endian_memory_top #(
  parameter int STORE_BYTES = sbem_pkg::STORE_BYTES_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst,
  sbem_req_if.sink   req,
  sbem_rsp_if.source rsp,
  sbem_cfg_if.sink   cfg
);
  import sbem_pkg::*;

  logic [ADDR_W-1:0] base_address;
  logic              done_valid;
  logic              done_ready;
  rsp_t              done_rsp;
  logic              out_valid;
  rsp_t              out_rsp;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_address <= '0;
    end else if (cfg.valid) begin
      base_address <= cfg.base_address;
    end
  end

  sbem_seq #(
    .STORE_BYTES(STORE_BYTES)
  ) u_seq (
    .clk          (clk),
    .rst          (rst),
    .req          (req),
    .base_address (base_address),
    .done_valid   (done_valid),
    .done_ready   (done_ready),
    .done_rsp     (done_rsp)
  );

  // The output register lets the sequencer start the next request while a result waits.
  assign done_ready = !out_valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (done_ready) begin
      out_valid <= done_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (done_ready && done_valid) begin
      out_rsp <= done_rsp;
    end
  end

  assign rsp.valid     = out_valid;
  assign rsp.read_data = out_rsp.read_data;
  assign rsp.fault     = out_rsp.fault;

endmodule
`default_nettype wire
